>>> rtl/core/smallest_prime_factor_factorizer_core_macros.svh
// ----------------------------------------------------------------------------
// smallest_prime_factor_factorizer_core_macros.svh
// Assertion macros shared by the factorizer RTL.
// ----------------------------------------------------------------------------
`ifndef SMALLEST_PRIME_FACTOR_FACTORIZER_CORE_MACROS_SVH
`define SMALLEST_PRIME_FACTOR_FACTORIZER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// implication or plain property, checked out of reset
`define SPFF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition that must never hold out of reset
`define SPFF_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SPFF_ASSERT(label, prop, msg)
`define SPFF_NEVER(label, cond, msg)
`endif

`endif

>>> rtl/core/spff_pkg.sv
// ----------------------------------------------------------------------------
// spff_pkg
// Types, constants and helpers of the smallest-prime-factor factorizer.
// ----------------------------------------------------------------------------
package spff_pkg;

  localparam int VALUE_W     = 16;
  localparam int VALUE_SPAN  = 65536;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // one table row: smallest prime factor and the quotient value / factor
  typedef struct packed {
    logic [VALUE_W-1:0] spf;
    logic [VALUE_W-1:0] quot;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // table port request; addresses are full value width, top trims them
  typedef struct packed {
    logic               we;
    logic [VALUE_W-1:0] waddr;
    entry_t             wdata;
    logic               re;
    logic [VALUE_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [1:0] {
    K_BAD,
    K_ONE,
    K_PLAIN
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } qhead_t;

  // row written by the initial pass, before any odd prime marks it
  function automatic entry_t init_entry(logic [VALUE_W-1:0] v);
    entry_t e;
    e.spf  = v;
    e.quot = VALUE_W'(1);
    if (v == '0) begin
      e.quot = '0;
    end else if (!v[0] && v >= VALUE_W'(4)) begin
      e.spf  = VALUE_W'(2);
      e.quot = v >> 1;
    end
    return e;
  endfunction

endpackage

>>> rtl/core/spff_if.sv
// ----------------------------------------------------------------------------
// spff_in_if / spff_out_if
// Valid/ready channels for input values and factor results.
// ----------------------------------------------------------------------------
interface spff_in_if import spff_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface spff_out_if import spff_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] factor;
  logic               last;
  logic               no_factors;
  logic               invalid;

  modport source (output valid, output factor, output last, output no_factors,
                  output invalid, input ready);
  modport sink   (input valid, input factor, input last, input no_factors,
                  input invalid, output ready);
endinterface

>>> rtl/core/spff_ram.sv
// ----------------------------------------------------------------------------
// spff_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module spff_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/spff_sieve.sv
// ----------------------------------------------------------------------------
// spff_sieve
// Builds the smallest-factor table after reset: one initial pass, then each
// odd prime marks its unmarked multiples from its square, one per cycle.
// ----------------------------------------------------------------------------
module spff_sieve import spff_pkg::*; #(
  parameter int BOUND = 65536
) (
  input  logic     clk,
  input  logic     rst_n,
  input  entry_t   rdata,
  output ram_req_t req,
  output logic     done
);

  localparam int CW = $clog2(BOUND) + 1;

  typedef enum logic [2:0] {
    S_INIT,
    S_SQUARE,
    S_CHECK,
    S_PRIME,
    S_MARK,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       p_r, p_nxt;
  logic [2*CW-1:0]     sq_r, sq_nxt;
  logic [VALUE_W-1:0]  k_r, k_nxt;
  logic                pend_r, pend_nxt;
  logic [CW-1:0]       pend_m_r, pend_m_nxt;
  logic [VALUE_W-1:0]  pend_k_r, pend_k_nxt;
  logic                done_r, done_nxt;
  logic                in_range;

  assign in_range = cnt_r < CW'(BOUND);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    p_nxt      = p_r;
    sq_nxt     = sq_r;
    k_nxt      = k_r;
    pend_nxt   = pend_r;
    pend_m_nxt = pend_m_r;
    pend_k_nxt = pend_k_r;
    done_nxt   = done_r;
    req        = '0;
    unique case (state_r)
      S_INIT: begin
        req.we    = 1'b1;
        req.waddr = VALUE_W'(cnt_r);
        req.wdata = init_entry(VALUE_W'(cnt_r));
        if (cnt_r == CW'(BOUND - 1)) begin
          p_nxt     = CW'(3);
          state_nxt = S_SQUARE;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_SQUARE: begin
        sq_nxt    = p_r * p_r;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sq_r >= (2*CW)'(BOUND)) begin
          done_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          req.re    = 1'b1;
          req.raddr = VALUE_W'(p_r);
          state_nxt = S_PRIME;
        end
      end
      S_PRIME: begin
        if (rdata.spf == VALUE_W'(p_r)) begin
          cnt_nxt   = CW'(sq_r);
          k_nxt     = VALUE_W'(p_r);
          pend_nxt  = 1'b0;
          state_nxt = S_MARK;
        end else begin
          p_nxt     = p_r + CW'(1);
          state_nxt = S_SQUARE;
        end
      end
      S_MARK: begin
        // read multiple m now, decide on the one read last cycle
        req.re     = in_range;
        req.raddr  = VALUE_W'(cnt_r);
        req.we     = pend_r && (rdata.spf == VALUE_W'(pend_m_r));
        req.waddr  = VALUE_W'(pend_m_r);
        req.wdata  = '{spf: VALUE_W'(p_r), quot: pend_k_r};
        pend_nxt   = in_range;
        pend_m_nxt = cnt_r;
        pend_k_nxt = k_r;
        if (in_range) begin
          cnt_nxt = cnt_r + p_r;
          k_nxt   = k_r + VALUE_W'(1);
        end else if (!pend_r) begin
          p_nxt     = p_r + CW'(1);
          state_nxt = S_SQUARE;
        end
      end
      S_DONE: begin
        done_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= '0;
      p_r     <= '0;
      pend_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      p_r     <= p_nxt;
      pend_r  <= pend_nxt;
      done_r  <= done_nxt;
    end
    sq_r     <= sq_nxt;
    k_r      <= k_nxt;
    pend_m_r <= pend_m_nxt;
    pend_k_r <= pend_k_nxt;
  end

  assign done = done_r;

endmodule

>>> rtl/core/spff_front.sv
// ----------------------------------------------------------------------------
// spff_front
// Accepts input words once the table is built and the queue is not full, and sorts
// them into invalid (zero or out-of-range), one, and ordinary values for the queue.
// ----------------------------------------------------------------------------
module spff_front import spff_pkg::*; #(
  parameter int BOUND = 65536
) (
  input  logic        table_ready,
  input  logic        q_full,
  spff_in_if.sink     in_ch,
  output logic        push,
  output qent_t       push_ent
);

  assign in_ch.ready = table_ready && !q_full;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    push_ent.value = in_ch.value;
    priority if (in_ch.value == '0 || {1'b0, in_ch.value} >= (VALUE_W+1)'(BOUND)) begin
      push_ent.kind = K_BAD;
    end else if (in_ch.value == VALUE_W'(1)) begin
      push_ent.kind = K_ONE;
    end else begin
      push_ent.kind = K_PLAIN;
    end
  end

endmodule

>>> rtl/core/spff_queue.sv
// ----------------------------------------------------------------------------
// spff_queue
// Short register FIFO between front and back.
// ----------------------------------------------------------------------------
`include "smallest_prime_factor_factorizer_core_macros.svh"

module spff_queue import spff_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  qent_t  push_ent,
  input  logic   pop,
  output logic   full,
  output qhead_t head
);

  qent_t               mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;
  logic                do_pop;

  assign full       = count_r == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign head.valid = count_r != '0;
  assign head.ent   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      end
      unique case ({push, do_pop})
        2'b10:   count_r <= count_r + (QUEUE_AW+1)'(1);
        2'b01:   count_r <= count_r - (QUEUE_AW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

  `SPFF_NEVER(a_no_overflow, push && full && !do_pop, "push into full queue")
  `SPFF_ASSERT(a_count_bound, count_r <= (QUEUE_AW+1)'(QUEUE_DEPTH), "queue count out of range")

endmodule

>>> rtl/core/spff_back.sv
// ----------------------------------------------------------------------------
// spff_back
// Walks the factor table for each queued ordinary value: emit the smallest factor,
// continue at the stored quotient until it reaches one. Invalid values and one each get one flagged word.
// ----------------------------------------------------------------------------
`include "smallest_prime_factor_factorizer_core_macros.svh"

module spff_back import spff_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  qhead_t     head,
  output logic       pop,
  input  entry_t     rdata,
  output ram_req_t   req,
  spff_out_if.source out_ch
);

  typedef enum logic {
    B_IDLE,
    B_FACT
  } state_t;

  state_t             state_r, state_nxt;
  logic               valid_r, valid_nxt;
  logic [VALUE_W-1:0] factor_r, factor_nxt;
  logic               last_r, last_nxt;
  logic               none_r, none_nxt;
  logic               bad_r, bad_nxt;
  logic               ofree;

  assign ofree = !valid_r || out_ch.ready;

  always_comb begin
    state_nxt  = state_r;
    valid_nxt  = valid_r && !out_ch.ready;
    factor_nxt = factor_r;
    last_nxt   = last_r;
    none_nxt   = none_r;
    bad_nxt    = bad_r;
    pop        = 1'b0;
    req        = '0;
    req.raddr  = head.ent.value;
    unique case (state_r)
      B_IDLE: begin
        if (head.valid) begin
          unique case (head.ent.kind)
            K_BAD: begin
              if (ofree) begin
                pop        = 1'b1;
                valid_nxt  = 1'b1;
                factor_nxt = '0;
                last_nxt   = 1'b1;
                none_nxt   = 1'b0;
                bad_nxt    = 1'b1;
              end
            end
            K_ONE: begin
              if (ofree) begin
                pop        = 1'b1;
                valid_nxt  = 1'b1;
                factor_nxt = VALUE_W'(1);
                last_nxt   = 1'b1;
                none_nxt   = 1'b1;
                bad_nxt    = 1'b0;
              end
            end
            K_PLAIN: begin
              pop       = 1'b1;
              req.re    = 1'b1;
              state_nxt = B_FACT;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      B_FACT: begin
        // row of the remainder is in rdata; hold it until the output frees up
        if (ofree) begin
          valid_nxt  = 1'b1;
          factor_nxt = rdata.spf;
          last_nxt   = rdata.quot == VALUE_W'(1);
          none_nxt   = 1'b0;
          bad_nxt    = 1'b0;
          if (rdata.quot == VALUE_W'(1)) begin
            state_nxt = B_IDLE;
          end else begin
            req.re    = 1'b1;
            req.raddr = rdata.quot;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    factor_r <= factor_nxt;
    last_r   <= last_nxt;
    none_r   <= none_nxt;
    bad_r    <= bad_nxt;
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.factor     = factor_r;
  assign out_ch.last       = last_r;
  assign out_ch.no_factors = none_r;
  assign out_ch.invalid    = bad_r;

  `SPFF_ASSERT(a_prime_ge2, valid_r && !bad_r && !none_r |-> factor_r >= VALUE_W'(2), "factor below two")

endmodule

>>> rtl/core/smallest_prime_factor_factorizer_core.sv
// A taken value passes the queue register and, if ordinary, a registered table read
// before its first factor reaches the output register; then one factor per cycle
// while the output is not stalled. The walker takes one item at a time, one table
// read per factor. Reset (rst_n, synchronous) starts a table build (initial pass
// plus sieve marking); in_ch.ready stays low until done.
// ----------------------------------------------------------------------------
// smallest_prime_factor_factorizer_core
// Smallest-prime-factor factorizer: sieve, front, queue and table walker.
// ----------------------------------------------------------------------------
`include "smallest_prime_factor_factorizer_core_macros.svh"

module smallest_prime_factor_factorizer_core import spff_pkg::*; #(
  parameter int TABLE_SIZE = 65536
) (
  input  logic       clk,
  input  logic       rst_n,
  spff_in_if.sink    in_ch,
  spff_out_if.source out_ch
);

  localparam int Bound = (TABLE_SIZE < VALUE_SPAN) ? TABLE_SIZE : VALUE_SPAN;
  localparam int AW    = $clog2(Bound);

  ram_req_t             sieve_req, back_req, ram_req;
  logic [ENTRY_W-1:0]   ram_rdata;
  entry_t               rdata;
  logic                 table_ready;
  logic                 q_full, push, pop;
  qent_t                push_ent;
  qhead_t               head;

  assign ram_req = table_ready ? back_req : sieve_req;
  assign rdata   = entry_t'(ram_rdata);

  spff_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (Bound)
  ) u_table (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr[AW-1:0]),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr[AW-1:0]),
    .rdata (ram_rdata)
  );

  spff_sieve #(
    .BOUND (Bound)
  ) u_sieve (
    .clk   (clk),
    .rst_n (rst_n),
    .rdata (rdata),
    .req   (sieve_req),
    .done  (table_ready)
  );

  spff_front #(
    .BOUND (Bound)
  ) u_front (
    .table_ready (table_ready),
    .q_full      (q_full),
    .in_ch       (in_ch),
    .push        (push),
    .push_ent    (push_ent)
  );

  spff_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .full     (q_full),
    .head     (head)
  );

  spff_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .rdata  (rdata),
    .req    (back_req),
    .out_ch (out_ch)
  );

  `SPFF_ASSERT(a_no_input_early, !table_ready |-> !in_ch.ready, "input taken before table built")
  `SPFF_NEVER(a_no_late_write, table_ready && sieve_req.we, "sieve writes after table built")
  `SPFF_ASSERT(a_ready_sticky, table_ready |=> table_ready, "table ready dropped")

endmodule
